// File: hw/rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
package wsfd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int OPCODE_W = 4;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 32;

    localparam logic [LEN_W-1:0]  FRAME_LIMIT_RESET = 16'd1024;
    localparam logic [BYTE_W-1:0] MASK_BIT          = 8'h80;
    localparam logic [BYTE_W-1:0] LEN_CODE_MASK     = 8'h7F;
    localparam logic [BYTE_W-1:0] OPCODE_MASK       = 8'h0F;
    localparam logic [6:0]        LEN_CODE_EXT16    = 7'd126;
    localparam logic [6:0]        LEN_CODE_EXT64    = 7'd127;
    localparam logic [2:0]        HDR_LEN_SHORT     = 3'd2;
    localparam logic [2:0]        HDR_LEN_EXT16     = 3'd4;
    localparam logic [2:0]        KEY_LEN           = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LEN64     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4,
        PH_FAILED = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                data_valid;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                last_of_frame;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// File: hw/rtl/websocket_frame_decoder.sv
// Top level of the byte-serial WebSocket frame decoder.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one stream byte per word.
//   Output channel (out_valid/out_ready) carries at most one result word per
//   input byte: payload_byte, data_valid, frame_opcode, last_of_frame, status.
//   Header bytes, extended length and mask key produce no word; each payload
//   byte produces one unmasked word; an empty frame produces one word with
//   data_valid low; a 64-bit length code or a frame over frame_limit produces
//   one error word, after which all input is swallowed until reset.
//   cfg_write_en/cfg_write_data write frame_limit (whole frame size in bytes,
//   header included); write it only while the decoder is idle.
// Timing:
//   One byte per cycle while out_ready stays high. A byte is captured in the
//   input register, parsed once the result slot is free or draining, and its
//   result then loads into the output register, which drives out_valid.
//   The parser between the two registers is combinational.
// Reset: parser returns to the first header byte, frame_limit to 1024.
// Stall: while out_ready is low and a result waits, the input register holds
//   its byte and in_ready drops once it is full.
module websocket_frame_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [wsfd_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wsfd_pkg::BYTE_W-1:0]         payload_byte,
    output logic                                data_valid,
    output logic [wsfd_pkg::OPCODE_W-1:0]       frame_opcode,
    output logic                                last_of_frame,
    output logic [wsfd_pkg::STATUS_W-1:0]       status,
    input  logic                                cfg_write_en,
    input  logic [wsfd_pkg::LEN_W-1:0]          cfg_write_data
);
    import wsfd_pkg::*;

    logic [LEN_W-1:0]  frame_limit_reg;
    logic              in_full_reg, in_full_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    logic              has_result;
    result_t           result;
    result_t           out_data;

    // frame limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= FRAME_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            frame_limit_reg <= cfg_write_data;
        end
    end

    // input register: byte moves on once the result slot is free or draining
    assign advance  = in_full_reg && (!out_valid || out_ready);
    assign in_ready = !in_full_reg || advance;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    wsfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .frame_limit (frame_limit_reg),
        .has_result  (has_result),
        .result      (result)
    );

    wsfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (has_result),
        .load_data (result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign payload_byte  = out_data.payload_byte;
    assign data_valid    = out_data.data_valid;
    assign frame_opcode  = out_data.frame_opcode;
    assign last_of_frame = out_data.last_of_frame;
    assign status        = out_data.status;

endmodule

// File: hw/rtl/wsfd_parser.sv
// Frame parser: header/length/key state and per-byte unmasking.
module wsfd_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [wsfd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [wsfd_pkg::LEN_W-1:0]   frame_limit,
    output logic                         has_result,
    output wsfd_pkg::result_t            result
);
    import wsfd_pkg::*;

    phase_t              phase_reg,     phase_next;
    logic [1:0]          hdr_idx_reg,   hdr_idx_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic [KEY_W-1:0]    mask_key_reg,  mask_key_next;
    logic                masked_reg,    masked_next;
    logic [OPCODE_W-1:0] opcode_reg,    opcode_next;
    logic [1:0]          key_pos_reg,   key_pos_next;

    logic                len_known;
    logic [2:0]          hdr_len;
    logic [LEN_W:0]      total;
    logic [BYTE_W-1:0]   key_byte;
    logic [6:0]          len_code;
    logic [LEN_W-1:0]    rem_dec;

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        remaining_next = remaining_reg;
        mask_key_next  = mask_key_reg;
        masked_next    = masked_reg;
        opcode_next    = opcode_reg;
        key_pos_next   = key_pos_reg;
        has_result     = 1'b0;
        result         = '{payload_byte: '0, data_valid: 1'b0, frame_opcode: opcode_reg,
                           last_of_frame: 1'b1, status: STATUS_OK};
        len_known      = 1'b0;
        hdr_len        = HDR_LEN_SHORT;
        len_code       = rx_byte[6:0] & LEN_CODE_MASK[6:0];
        rem_dec        = remaining_reg - 1'b1;
        key_byte       = '0;

        unique case (key_pos_reg)
            2'd0: key_byte = mask_key_reg[31:24];
            2'd1: key_byte = mask_key_reg[23:16];
            2'd2: key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
        if (!masked_reg)
        begin
            key_byte = '0;
        end

        if (step)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[OPCODE_W-1:0] & OPCODE_MASK[OPCODE_W-1:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = (rx_byte & MASK_BIT) != '0;
                    if (len_code == LEN_CODE_EXT64)
                    begin
                        phase_next    = PH_FAILED;
                        has_result    = 1'b1;
                        result.status = STATUS_LEN64;
                    end
                    else if (len_code == LEN_CODE_EXT16)
                    begin
                        hdr_idx_next   = '0;
                        remaining_next = '0;
                        phase_next     = PH_EXTLEN;
                    end
                    else
                    begin
                        remaining_next = {{(LEN_W-7){1'b0}}, len_code};
                        len_known      = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    remaining_next = {remaining_reg[LEN_W-BYTE_W-1:0], rx_byte};
                    if (hdr_idx_reg == 2'd0)
                    begin
                        hdr_idx_next = 2'd1;
                    end
                    else
                    begin
                        hdr_len   = HDR_LEN_EXT16;
                        len_known = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    mask_key_next = {mask_key_reg[KEY_W-BYTE_W-1:0], rx_byte};
                    hdr_idx_next  = hdr_idx_reg + 2'd1;
                    if (hdr_idx_reg == 2'd3)
                    begin
                        if (remaining_reg == '0)
                        begin
                            phase_next = PH_HDR0;
                            has_result = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    key_pos_next   = key_pos_reg + 2'd1;
                    remaining_next = rem_dec;
                    has_result     = 1'b1;
                    result.payload_byte  = rx_byte ^ key_byte;
                    result.data_valid    = 1'b1;
                    result.last_of_frame = (rem_dec == '0);
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_FAILED;
                end
            endcase
        end

        // length now known: limit check, then key, payload or empty frame
        total = {1'b0, remaining_next} + {{(LEN_W-2){1'b0}}, hdr_len}
              + (masked_next ? {{(LEN_W-2){1'b0}}, KEY_LEN} : '0);
        if (len_known)
        begin
            if (total > {1'b0, frame_limit})
            begin
                phase_next    = PH_FAILED;
                has_result    = 1'b1;
                result.status = STATUS_TOO_LARGE;
            end
            else
            begin
                hdr_idx_next = '0;
                key_pos_next = '0;
                if (masked_next)
                begin
                    mask_key_next = '0;
                    phase_next    = PH_KEY;
                end
                else if (remaining_next == '0)
                begin
                    phase_next = PH_HDR0;
                    has_result = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            hdr_idx_reg   <= '0;
            remaining_reg <= '0;
            mask_key_reg  <= '0;
            masked_reg    <= 1'b0;
            opcode_reg    <= '0;
            key_pos_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            remaining_reg <= remaining_next;
            mask_key_reg  <= mask_key_next;
            masked_reg    <= masked_next;
            opcode_reg    <= opcode_next;
            key_pos_reg   <= key_pos_next;
        end
    end

endmodule

// File: hw/rtl/wsfd_out_reg.sv
// Result register with valid/ready handshake toward the receiver.
module wsfd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  wsfd_pkg::result_t load_data,
    output logic              out_valid,
    input  logic              out_ready,
    output wsfd_pkg::result_t out_data
);
    import wsfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
